// ===== rtl/core/ifd_pkg.sv =====
// Shared types and constants for the frame deframer.
`default_nettype none
package ifd_pkg;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hFA;
  localparam logic [7:0] BUS_ID_BYTE   = 8'hFF;
  localparam logic [7:0] CHECK_START   = 8'h01;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_BUSID   = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] message_id;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] payload_length;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/ifd_rx_if.sv =====
// Received byte channel: valid/ready handshake with one byte per word.
`default_nettype none
interface ifd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ifd_res_if.sv =====
// Result channel: payload bytes and frame end words.
`default_nettype none
interface ifd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] message_id;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic [7:0] payload_length;
  logic       last;

  modport source (output valid, output kind, output message_id, output payload_byte,
                  output byte_index, output payload_length, output last, input ready);
  modport sink   (input valid, input kind, input message_id, input payload_byte,
                  input byte_index, input payload_length, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/imu_frame_deframer.sv =====
// Frame deframer top level: byte state machine between input and result registers.
//
// Usage:
//   rx_i carries one received byte per word. res_o carries one word per
//   payload byte (kind payload, with its index in the frame) and one word at
//   the checksum byte (kind good or bad, last set). Hunt, bus-id, id and
//   length bytes produce no word.
//   A byte accepted on rx_i is held in the input register, runs through the
//   state machine and is written to the result register; its word is shown
//   on res_o from then on.
//   Throughput: one byte per cycle while res_o is not held, set by the state
//   update between the input register and the result register.
//   Reset: the state machine hunts for the preamble, the check value is
//   0x01 and both registers are empty.
//   Stall: while res_o is held, the input register keeps its byte and
//   rx_i.ready drops once that register is full; nothing is dropped.
`default_nettype none
module imu_frame_deframer (
  input  wire        clk_i,
  input  wire        rst_ni,
  ifd_rx_if.sink     rx_i,
  ifd_res_if.source  res_o
);
  import ifd_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // frame state
  phase_e     phase_q, phase_d;
  logic [7:0] check_q, check_d;
  logic [7:0] id_q, id_d;
  logic [7:0] len_q, len_d;
  logic [7:0] taken_q, taken_d;

  // result register
  logic       res_valid_q;
  result_t    res_q;
  result_t    res_d;
  logic       emit;

  logic       res_free;
  logic       in_fire;
  logic       rx_take;
  logic [7:0] taken_inc;

  assign res_free  = !res_valid_q || res_o.ready;
  assign in_fire   = in_valid_q && res_free;
  assign rx_i.ready = !in_valid_q || res_free;
  assign rx_take   = rx_i.valid && rx_i.ready;
  assign taken_inc = taken_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_take) begin
      in_valid_q <= 1'b1;
    end else if (in_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      check_q <= CHECK_START;
      id_q    <= 8'd0;
      len_q   <= 8'd0;
      taken_q <= 8'd0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      check_q <= check_d;
      id_q    <= id_d;
      len_q   <= len_d;
      taken_q <= taken_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    check_d = check_q;
    id_d    = id_q;
    len_d   = len_q;
    taken_d = taken_q;
    emit    = 1'b0;
    res_d.kind           = KIND_PAYLOAD;
    res_d.message_id     = id_q;
    res_d.payload_byte   = 8'd0;
    res_d.byte_index     = 8'd0;
    res_d.payload_length = len_q;
    res_d.last           = 1'b0;
    case (phase_q)
      PH_HUNT: begin
        if (in_byte_q == PREAMBLE_BYTE) begin
          phase_d = PH_BUSID;
        end
      end
      PH_BUSID: begin
        // a wrong bus id is dropped, not retried as a preamble
        phase_d = (in_byte_q == BUS_ID_BYTE) ? PH_ID : PH_HUNT;
      end
      PH_ID: begin
        id_d    = in_byte_q;
        check_d = CHECK_START - in_byte_q;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d   = in_byte_q;
        check_d = check_q - in_byte_q;
        taken_d = 8'd0;
        phase_d = (in_byte_q == 8'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        check_d            = check_q - in_byte_q;
        emit               = 1'b1;
        res_d.payload_byte = in_byte_q;
        res_d.byte_index   = taken_q;
        taken_d            = taken_inc;
        if (taken_inc == len_q) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        emit       = 1'b1;
        res_d.kind = (check_q == in_byte_q) ? KIND_GOOD : KIND_BAD;
        res_d.last = 1'b1;
        phase_d    = PH_HUNT;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= in_fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.kind           = res_q.kind;
  assign res_o.message_id     = res_q.message_id;
  assign res_o.payload_byte   = res_q.payload_byte;
  assign res_o.byte_index     = res_q.byte_index;
  assign res_o.payload_length = res_q.payload_length;
  assign res_o.last           = res_q.last;

  // payload phase always has bytes left to take
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> (len_q != 8'd0) && (taken_q < len_q))
    else $error("payload phase with no bytes left");

  // checksum byte ends the frame with a last word and a return to hunting
  a_check_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_CHECK |=> phase_q == PH_HUNT && res_valid_q && res_q.last)
    else $error("checksum byte did not close the frame");

  // an empty input register never blocks the byte channel
  a_rx_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> rx_i.ready)
    else $error("input stalled while its register is empty");

  // last marks exactly the frame end words
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.last == (res_q.kind != KIND_PAYLOAD)))
    else $error("last and kind disagree");

endmodule
`default_nettype wire
